// ----- hw/rtl/skhs_pkg.sv -----
// skhs_pkg: shared constants and types for the word hash set block
// no dependencies; imported by skhs_div, the top level and the testbench
package skhs_pkg;

  // field widths of the result item
  localparam int SLOT_W   = 10;
  localparam int STATUS_W = 2;
  localparam int HASH_W   = 32;

  // only the low 31 bits of the hash pick the home slot
  localparam logic [HASH_W-1:0] HASH_MASK = 32'h7fff_ffff;
  localparam int DIVIDEND_W = 31;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG = 2'd2;

  // operation codes
  localparam logic OP_SEARCH = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_TABLE_SIZE = 2'd0;
  localparam logic [1:0] REG_HASH_SEED  = 2'd1;
  localparam logic [1:0] REG_PROBE_STEP = 2'd2;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/skhs_div.sv -----
// skhs_div: restoring remainder unit, one quotient bit per cycle
// depends on skhs_pkg (div_stat_t)
module skhs_div import skhs_pkg::*; #(
  parameter int DW = 31,
  parameter int NW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic [NW-1:0] rem,
  output div_stat_t     stat
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [NW:0]   trial;

  // load on start, else one shift-subtract step
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[DW-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt = q_r << 1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = NW'(trial - {1'b0, den_r});
      end else begin
        rem_nxt = NW'(trial);
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rem       = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTHESIS
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && den_r != '0 |-> rem_r < den_r) else $error("remainder not reduced");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule

// ----- hw/rtl/string_key_hash_set_linear_probe_unit.sv -----
// string_key_hash_set_linear_probe_unit: word hash set with linear probing
// depends on skhs_pkg and skhs_div
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata key_byte, tuser operation, tlast last_byte
//  out_    | out | out_tvalid/tready  | tdata found, slot, status
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// a non-last byte is taken in S_IDLE; a last byte of a word within the limit runs two remainder passes
// (hash and step) in skhs_div, then S_MRD/S_MCHK per probe and S_CRD/S_CCHK per compared byte,
// then on an insert with room S_WKEY per stored byte and S_WMETA, then S_DONE fills the output register
// after reset a clearing pass over all TABLE_SLOTS slots empties the slot map
// while it runs, and while a word is processed, no item is accepted
// one finished result waits in the output register; bytes keep flowing meanwhile, but the next result waits in S_DONE
module string_key_hash_set_linear_probe_unit import skhs_pkg::*; #(
  parameter int TABLE_SLOTS    = 1024,
  parameter int MAX_WORD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] key_byte
  input  logic        in_tuser,   // [0] operation
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] found, [10:1] slot, [12:11] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int SZW = $clog2(TABLE_SLOTS + 1);
  localparam int LW  = $clog2(MAX_WORD_BYTES + 1);
  localparam int IW  = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam int KD  = TABLE_SLOTS << IW;

  // sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DIVH  = 4'd2;
  localparam logic [3:0] S_DIVS  = 4'd3;
  localparam logic [3:0] S_MRD   = 4'd4;
  localparam logic [3:0] S_MCHK  = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;
  localparam logic [3:0] S_CCHK  = 4'd7;
  localparam logic [3:0] S_WKEY  = 4'd8;
  localparam logic [3:0] S_WMETA = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [10:0]       tsize_r;
  logic [31:0]       seed_r;
  logic [9:0]        step_r;
  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              long_r, long_nxt;
  logic              op_r, op_nxt;
  logic [LW-1:0]     plen_r, plen_nxt;
  logic [SW-1:0]     home_r, home_nxt;
  logic [SW-1:0]     addr_r, addr_nxt;
  logic [SW-1:0]     stepm_r, stepm_nxt;
  logic [SZW-1:0]    n_r, n_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [SZW-1:0]    cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  logic [7:0]        wbuf_r [MAX_WORD_BYTES];
  logic [7:0]        key_mem [KD];
  logic [LW:0]       meta_mem [TABLE_SLOTS];
  logic [7:0]        key_q;
  logic [LW:0]       meta_q;

  logic              in_acc;
  logic [SZW-1:0]    size_a;
  logic [HASH_W-1:0] h_base, c32, h_new;
  logic              long_now;
  logic              stop, sfound, adv;
  logic [SZW:0]      psum, padv;
  logic [SZW-1:0]    n_inc;
  logic              div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [SZW-1:0]    div_rem;
  div_stat_t         div_stat;
  logic              meta_we, key_we;
  logic [SW-1:0]     meta_wa;
  logic [LW:0]       meta_wd;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // active table size, clamped to the supported range
  always_comb begin
    if (tsize_r < 11'd2) begin
      size_a = SZW'(2);
    end else if (32'(tsize_r) > 32'(TABLE_SLOTS)) begin
      size_a = SZW'(TABLE_SLOTS);
    end else begin
      size_a = SZW'(tsize_r);
    end
  end

  // running hash update for the incoming byte
  assign h_base   = (len_r == '0 && !long_r) ? seed_r : hash_r;
  assign c32      = {{24{in_tdata[7]}}, in_tdata};
  assign h_new    = h_base ^ ((h_base << 5) + c32 + (h_base >> 2));
  assign long_now = long_r || (32'(len_r) >= 32'(MAX_WORD_BYTES));

  // remainder unit: hash mod size, then step mod size
  assign div_dividend = (state_r == S_IDLE) ? h_new[DIVIDEND_W-1:0] & HASH_MASK[DIVIDEND_W-1:0]
                                            : DIVIDEND_W'(step_r);

  skhs_div #(.DW(DIVIDEND_W), .NW(SZW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (size_a),
    .rem      (div_rem),
    .stat     (div_stat)
  );

  // next probe address
  assign psum  = (SZW+1)'(addr_r) + (SZW+1)'(stepm_r);
  assign padv  = (psum >= (SZW+1)'(size_a)) ? psum - (SZW+1)'(size_a) : psum;
  assign n_inc = n_r + SZW'(1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    len_nxt       = len_r;
    long_nxt      = long_r;
    op_nxt        = op_r;
    plen_nxt      = plen_r;
    home_nxt      = home_r;
    addr_nxt      = addr_r;
    stepm_nxt     = stepm_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    stop          = 1'b0;
    sfound        = 1'b0;
    adv           = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          hash_nxt = h_new;
          long_nxt = long_now;
          if (!long_now) begin
            len_nxt = len_r + LW'(1);
          end
          if (in_tlast) begin
            op_nxt   = in_tuser;
            plen_nxt = len_r + LW'(1);
            len_nxt  = '0;
            long_nxt = 1'b0;
            if (long_now) begin
              found_nxt  = 1'b0;
              addr_nxt   = '0;
              status_nxt = ST_LONG;
              state_nxt  = S_DONE;
            end else begin
              div_start = 1'b1;
              state_nxt = S_DIVH;
            end
          end
        end
      end
      S_DIVH: begin
        if (div_stat.done) begin
          home_nxt  = SW'(div_rem);
          addr_nxt  = SW'(div_rem);
          div_start = 1'b1;
          state_nxt = S_DIVS;
        end
      end
      S_DIVS: begin
        if (div_stat.done) begin
          stepm_nxt = SW'(div_rem);
          n_nxt     = '0;
          state_nxt = S_MRD;
        end
      end
      S_MRD: begin
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (!meta_q[LW]) begin
          stop = 1'b1;
        end else if (meta_q[LW-1:0] == plen_r) begin
          idx_nxt   = '0;
          state_nxt = S_CRD;
        end else begin
          adv = 1'b1;
        end
      end
      S_CRD: begin
        state_nxt = S_CCHK;
      end
      S_CCHK: begin
        if (key_q != wbuf_r[idx_r]) begin
          adv = 1'b1;
        end else if (LW'(idx_r) == plen_r - LW'(1)) begin
          stop   = 1'b1;
          sfound = 1'b1;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_CRD;
        end
      end
      S_WKEY: begin
        if (LW'(idx_r) == plen_r - LW'(1)) begin
          state_nxt = S_WMETA;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_WMETA: begin
        cnt_nxt   = cnt_r + SZW'(1);
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 16'({status_r, SLOT_W'(addr_r), found_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // move to the next slot, or give up after a full lap
    if (adv) begin
      if (n_inc == size_a) begin
        found_nxt  = 1'b0;
        addr_nxt   = home_r;
        status_nxt = ST_FULL;
        state_nxt  = S_DONE;
      end else begin
        n_nxt     = n_inc;
        addr_nxt  = SW'(padv);
        state_nxt = S_MRD;
      end
    end

    // empty or matching slot reached
    if (stop) begin
      found_nxt = sfound;
      if (op_r == OP_INSERT) begin
        if ((SZW+1)'(cnt_r) + (SZW+1)'(1) >= (SZW+1)'(size_a)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          status_nxt = ST_OK;
          idx_nxt    = '0;
          state_nxt  = S_WKEY;
        end
      end else begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      len_r       <= '0;
      long_r      <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      len_r       <= len_nxt;
      long_r      <= long_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsize_r <= 11'd1021;
      seed_r  <= '0;
      step_r  <= 10'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TABLE_SIZE: tsize_r <= cfg_data[10:0];
        REG_HASH_SEED:  seed_r  <= cfg_data;
        REG_PROBE_STEP: step_r  <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    op_r       <= op_nxt;
    plen_r     <= plen_nxt;
    home_r     <= home_nxt;
    addr_r     <= addr_nxt;
    stepm_r    <= stepm_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  // word buffer
  always_ff @(posedge clk) begin
    if (in_acc && !long_now) begin
      wbuf_r[len_r[IW-1:0]] <= in_tdata;
    end
  end

  // slot map: used bit and stored length per slot
  assign meta_we = (state_r == S_CLEAR) || (state_r == S_WMETA);
  assign meta_wa = (state_r == S_CLEAR) ? clr_r : addr_r;
  assign meta_wd = (state_r == S_CLEAR) ? '0 : {1'b1, plen_r};
  assign key_we  = (state_r == S_WKEY);

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_q <= meta_mem[addr_r];
  end

  // stored key bytes, one row of bytes per slot
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{addr_r, idx_r}] <= wbuf_r[idx_r];
    end
    key_q <= key_mem[{addr_r, idx_r}];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MCHK |-> 32'(addr_r) < 32'(size_a)) else $error("probe slot out of range");
  a_cmp_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CCHK |-> LW'(idx_r) < plen_r) else $error("compare index past word");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WMETA |=> cnt_r == $past(cnt_r) + SZW'(1)) else $error("count not raised");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIVH || state_r == S_DIVS |-> div_stat.busy || div_stat.done)
    else $error("waiting on idle divider");
`endif

endmodule

// ----- tb/string_key_hash_set_linear_probe_unit_tb.sv -----
// testbench for the word hash set block: bytes stream in, search/insert results stream out
// a scoreboard class predicts every result; tasks drive the item and register channels
// depends on skhs_pkg and the rtl of string_key_hash_set_linear_probe_unit
`timescale 1ns / 1ps

import skhs_pkg::*;

typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic                found;
} lookup_result_t;

class hash_set_scoreboard;
  // register copies
  logic [10:0]       tbl_size;
  logic [31:0]       seed;
  logic [9:0]        step;
  // word being assembled
  logic [7:0]        word_buf[32];
  int unsigned       word_len;
  bit                too_long;
  logic [31:0]       run_hash;
  // table contents
  logic [7:0]        slot_bytes[1024][32];
  int unsigned       slot_len[1024];
  bit                slot_used[1024];
  logic [10:0]       elem_count;
  lookup_result_t    expected_q[$];
  int                mismatches;

  function new();
    tbl_size   = 11'd1021;
    seed       = '0;
    step       = 10'd1;
    word_len   = 0;
    too_long   = 0;
    run_hash   = '0;
    elem_count = '0;
    mismatches = 0;
    foreach (slot_used[i]) slot_used[i] = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] d);
    case (idx)
      REG_TABLE_SIZE: tbl_size = d[10:0];
      REG_HASH_SEED:  seed = d;
      REG_PROBE_STEP: step = d[9:0];
      default: ;
    endcase
  endfunction

  function bit same_word(int unsigned s);
    if (slot_len[s] != word_len) return 0;
    for (int unsigned k = 0; k < word_len; k++)
      if (slot_bytes[s][k] != word_buf[k]) return 0;
    return 1;
  endfunction

  // note one accepted input item
  function void take_byte(logic op, logic [7:0] b, logic last);
    logic [31:0]    c;
    int unsigned    size, home, addr;
    bit             stopped;
    lookup_result_t r;
    if (word_len == 0 && !too_long) run_hash = seed;
    c = {{24{b[7]}}, b};
    run_hash = run_hash ^ ((run_hash << 5) + c + (run_hash >> 2));
    if (word_len < 32) begin
      word_buf[word_len] = b;
      word_len++;
    end else begin
      too_long = 1;
    end
    if (!last) return;
    r = '0;
    if (too_long) begin
      r.status = ST_LONG;
    end else begin
      size = (tbl_size < 2) ? 2 : (tbl_size > 1024) ? 1024 : tbl_size;
      home = (run_hash & HASH_MASK) % size;
      addr = home;
      stopped = 0;
      for (int unsigned n = 0; n < size; n++) begin
        if (!slot_used[addr]) begin
          stopped = 1;
          break;
        end
        if (same_word(addr)) begin
          stopped = 1;
          r.found = 1;
          break;
        end
        addr = (addr + step) % size;
      end
      r.status = ST_OK;
      if (!stopped) begin
        addr = home;
        r.found = 0;
        r.status = ST_FULL;
      end else if (op == OP_INSERT) begin
        if (elem_count + 1 >= size) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned k = 0; k < word_len; k++) slot_bytes[addr][k] = word_buf[k];
          slot_len[addr] = word_len;
          slot_used[addr] = 1;
          elem_count = elem_count + 11'd1;
        end
      end
      r.slot = addr[9:0];
    end
    expected_q.push_back(r);
    word_len = 0;
    too_long = 0;
    run_hash = seed;
  endfunction

  // compare one accepted result item with the oldest expectation
  function void check_result(logic [15:0] d);
    lookup_result_t got, exp_r;
    got = d[12:0];
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item: actual %h", got);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.found !== exp_r.found || got.slot !== exp_r.slot
        || got.status !== exp_r.status || d[15:13] !== 3'b0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected found %0d slot %0d status %0d, actual found %0d slot %0d status %0d",
                 exp_r.found, exp_r.slot, exp_r.status, got.found, got.slot, got.status);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module string_key_hash_set_linear_probe_unit_tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] key_byte
  logic        in_tuser = 0;    // [0] operation
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;       // [0] found, [10:1] slot, [12:11] status
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  hash_set_scoreboard sb = new();

  bit          tx_no_gaps;
  bit          rx_no_gaps;
  int          results_seen;
  // words reused so that searches and inserts hit stored entries
  logic [7:0]  pool_b[16][8];
  int          pool_len[16];

  string_key_hash_set_linear_probe_unit u_top (.*);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // one input item
  task automatic send_byte(logic op, logic [7:0] b, logic last);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata  = b;
    in_tuser  = op;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(op, b, last);
    @(negedge clk);
  endtask

  task automatic send_word(logic op, logic [7:0] w[], int len);
    for (int k = 0; k < len; k++) send_byte(1'($urandom_range(0, 1)), w[k], 0);
    send_byte(op, w[len], 1);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic wait_drained();
    in_tvalid = 0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // random words: mostly reused short words, some fresh, some long ones of 31 to 40 bytes, most over the length limit
  task automatic random_word();
    logic [7:0] w[];
    int         pick, len, roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      len = $urandom_range(31, 40);
      w = new[len];
      foreach (w[k]) w[k] = 8'($urandom_range(0, 255));
    end else begin
      pick = $urandom_range(0, 15);
      if (roll < 30) begin
        pool_len[pick] = $urandom_range(1, 8);
        for (int k = 0; k < 8; k++) pool_b[pick][k] = 8'($urandom_range(0, 255));
      end
      len = pool_len[pick];
      w = new[len];
      foreach (w[k]) w[k] = pool_b[pick][k];
    end
    send_word(1'($urandom_range(0, 1)), w, len - 1);
  endtask

  // result side
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = rx_no_gaps ? 0 : $urandom_range(0, 9);
      if (results_seen == 60) stall = 400;
      if (stall > 0) begin
        out_tready = 0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      results_seen++;
      @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [7:0]  w[];
    logic [10:0] sizes[6];
    sizes = '{11'd3, 11'd7, 11'd13, 11'd31, 11'd97, 11'd64};
    for (int i = 0; i < 16; i++) begin
      pool_len[i] = $urandom_range(1, 8);
      for (int k = 0; k < 8; k++) pool_b[i][k] = 8'($urandom_range(0, 255));
    end
    repeat (11) @(negedge clk);
    rst_n = 1;

    // directed: byte extremes, both operations, search miss and hit, reset config
    tx_no_gaps = 1;
    rx_no_gaps = 1;
    send_byte(OP_SEARCH, 8'h61, 1);
    send_byte(OP_INSERT, 8'h61, 1);
    send_byte(OP_SEARCH, 8'h61, 1);
    send_byte(OP_INSERT, 8'h61, 1);
    w = '{8'h00, 8'hff, 8'h80, 8'h7f};
    send_word(OP_INSERT, w, 3);
    send_word(OP_SEARCH, w, 3);
    send_byte(OP_INSERT, 8'hff, 1);
    send_byte(OP_SEARCH, 8'h00, 1);
    wait_drained();
    repeat (200) @(negedge clk);

    // below-range size acts as two slots: the table is full at once
    write_reg(REG_TABLE_SIZE, 32'd0);
    send_byte(OP_INSERT, 8'h11, 1);
    send_byte(OP_SEARCH, 8'h61, 1);
    wait_drained();
    repeat (200) @(negedge clk);

    // above-range size (clamped to 1024) with step 1023, then a step of zero that keeps revisiting the home slot
    write_reg(REG_TABLE_SIZE, 32'd2047);
    write_reg(REG_HASH_SEED, 32'hffff_ffff);
    write_reg(REG_PROBE_STEP, 32'd1023);
    for (int i = 0; i < 4; i++) send_byte(OP_INSERT, 8'($urandom_range(0, 255)), 1);
    wait_drained();
    repeat (200) @(negedge clk);
    write_reg(REG_TABLE_SIZE, 32'd8);
    write_reg(REG_PROBE_STEP, 32'd0);
    for (int i = 0; i < 3; i++) send_byte(OP_SEARCH, 8'($urandom_range(0, 255)), 1);

    // random phases, each with its own register setting
    for (int ph = 0; ph < 9; ph++) begin
      wait_drained();
      repeat (200) @(negedge clk);
      write_reg(REG_TABLE_SIZE, (ph == 8) ? 32'd1024 : 32'(sizes[$urandom_range(0, 5)]));
      write_reg(REG_HASH_SEED, $urandom());
      write_reg(REG_PROBE_STEP, (ph % 3 == 0) ? 32'd1 : 32'($urandom_range(0, 1023)));
      tx_no_gaps = (ph % 4 == 1);
      rx_no_gaps = (ph % 4 == 2);
      for (int n = 0; n < 21; n++) begin
        if (ph == 3 && n == 15) wait_drained();
        random_word();
      end
    end
    wait_drained();
    repeat (500) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
